// ===== src/lmfb_pkg.sv =====
// lmfb_pkg: shared types, constants and the 5x7 font lookup for the led matrix framebuffer
// no dependencies
`timescale 1ns / 1ps
package lmfb_pkg;

  localparam int MAX_MODULES = 4;
  localparam int FB_WIDTH    = 8 * MAX_MODULES;
  localparam int ROWS        = 8;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_PIXEL   = 3'd1;
  localparam logic [2:0] OP_CHAR    = 3'd2;
  localparam logic [2:0] OP_BITMAP  = 3'd3;
  localparam logic [2:0] OP_REFRESH = 3'd4;

  localparam logic CFG_DEVICE_COUNT = 1'b0;
  localparam logic CFG_FLIP_VIEW    = 1'b1;

  localparam int GLYPH_UPPER_BASE = 11;
  localparam int GLYPH_LOWER_BASE = 37;
  localparam int GLYPH_PUNCT_BASE = 63;
  localparam int GLYPH_SWEDE_BASE = 94;

  // command queued between front and back
  typedef struct packed {
    logic [2:0]  opcode;
    logic signed [7:0] x_pos;
    logic [3:0]  y_pos;
    logic        pixel_on;
    logic [39:0] glyph;
    logic [63:0] bitmap;
    logic        bad;
  } cmd_t;

  function automatic logic [6:0] glyph_index(input logic [7:0] c);
    logic [6:0] idx;
    idx = 7'd0;
    if (c >= 8'h30 && c <= 8'h39) idx = 7'(1 + (c - 8'h30));
    else if (c >= 8'h41 && c <= 8'h5A) idx = 7'(GLYPH_UPPER_BASE + (c - 8'h41));
    else if (c >= 8'h61 && c <= 8'h7A) idx = 7'(GLYPH_LOWER_BASE + (c - 8'h61));
    else begin
      case (c)
        8'h2E: idx = 7'(GLYPH_PUNCT_BASE + 0);
        8'h2C: idx = 7'(GLYPH_PUNCT_BASE + 1);
        8'h3A: idx = 7'(GLYPH_PUNCT_BASE + 2);
        8'h3B: idx = 7'(GLYPH_PUNCT_BASE + 3);
        8'h21: idx = 7'(GLYPH_PUNCT_BASE + 4);
        8'h3F: idx = 7'(GLYPH_PUNCT_BASE + 5);
        8'h2D: idx = 7'(GLYPH_PUNCT_BASE + 6);
        8'h5F: idx = 7'(GLYPH_PUNCT_BASE + 7);
        8'h2B: idx = 7'(GLYPH_PUNCT_BASE + 8);
        8'h3D: idx = 7'(GLYPH_PUNCT_BASE + 9);
        8'h2F: idx = 7'(GLYPH_PUNCT_BASE + 10);
        8'h5C: idx = 7'(GLYPH_PUNCT_BASE + 11);
        8'h7C: idx = 7'(GLYPH_PUNCT_BASE + 12);
        8'h28: idx = 7'(GLYPH_PUNCT_BASE + 13);
        8'h29: idx = 7'(GLYPH_PUNCT_BASE + 14);
        8'h5B: idx = 7'(GLYPH_PUNCT_BASE + 15);
        8'h5D: idx = 7'(GLYPH_PUNCT_BASE + 16);
        8'h7B: idx = 7'(GLYPH_PUNCT_BASE + 17);
        8'h7D: idx = 7'(GLYPH_PUNCT_BASE + 18);
        8'h27: idx = 7'(GLYPH_PUNCT_BASE + 19);
        8'h22: idx = 7'(GLYPH_PUNCT_BASE + 20);
        8'h23: idx = 7'(GLYPH_PUNCT_BASE + 21);
        8'h24: idx = 7'(GLYPH_PUNCT_BASE + 22);
        8'h25: idx = 7'(GLYPH_PUNCT_BASE + 23);
        8'h26: idx = 7'(GLYPH_PUNCT_BASE + 24);
        8'h2A: idx = 7'(GLYPH_PUNCT_BASE + 25);
        8'h40: idx = 7'(GLYPH_PUNCT_BASE + 26);
        8'h3C: idx = 7'(GLYPH_PUNCT_BASE + 27);
        8'h3E: idx = 7'(GLYPH_PUNCT_BASE + 28);
        8'h5E: idx = 7'(GLYPH_PUNCT_BASE + 29);
        8'h7E: idx = 7'(GLYPH_PUNCT_BASE + 30);
        8'hC5: idx = 7'(GLYPH_SWEDE_BASE + 0);
        8'hC4: idx = 7'(GLYPH_SWEDE_BASE + 1);
        8'hD6: idx = 7'(GLYPH_SWEDE_BASE + 2);
        8'hE5: idx = 7'(GLYPH_SWEDE_BASE + 3);
        8'hE4: idx = 7'(GLYPH_SWEDE_BASE + 4);
        8'hF6: idx = 7'(GLYPH_SWEDE_BASE + 5);
        default: idx = 7'd0;
      endcase
    end
    return idx;
  endfunction

  // column 0 in bits 39:32, column 4 in bits 7:0
  function automatic logic [39:0] glyph_rom(input logic [6:0] i);
    logic [39:0] g;
    case (i)
      7'd1:  g = 40'h3E_51_49_45_3E; 7'd2:  g = 40'h00_42_7F_40_00;
      7'd3:  g = 40'h42_61_51_49_46; 7'd4:  g = 40'h21_41_45_4B_31;
      7'd5:  g = 40'h18_14_12_7F_10; 7'd6:  g = 40'h27_45_45_45_39;
      7'd7:  g = 40'h3C_4A_49_49_30; 7'd8:  g = 40'h01_71_09_05_03;
      7'd9:  g = 40'h36_49_49_49_36; 7'd10: g = 40'h06_49_49_29_1E;
      7'd11: g = 40'h7E_11_11_11_7E; 7'd12: g = 40'h7F_49_49_49_36;
      7'd13: g = 40'h3E_41_41_41_22; 7'd14: g = 40'h7F_41_41_22_1C;
      7'd15: g = 40'h7F_49_49_49_41; 7'd16: g = 40'h7F_09_09_09_01;
      7'd17: g = 40'h3E_41_49_49_7A; 7'd18: g = 40'h7F_08_08_08_7F;
      7'd19: g = 40'h00_41_7F_41_00; 7'd20: g = 40'h20_40_41_3F_01;
      7'd21: g = 40'h7F_08_14_22_41; 7'd22: g = 40'h7F_40_40_40_40;
      7'd23: g = 40'h7F_02_0C_02_7F; 7'd24: g = 40'h7F_04_08_10_7F;
      7'd25: g = 40'h3E_41_41_41_3E; 7'd26: g = 40'h7F_09_09_09_06;
      7'd27: g = 40'h3E_41_51_21_5E; 7'd28: g = 40'h7F_09_19_29_46;
      7'd29: g = 40'h46_49_49_49_31; 7'd30: g = 40'h01_01_7F_01_01;
      7'd31: g = 40'h3F_40_40_40_3F; 7'd32: g = 40'h1F_20_40_20_1F;
      7'd33: g = 40'h7F_20_18_20_7F; 7'd34: g = 40'h63_14_08_14_63;
      7'd35: g = 40'h03_04_78_04_03; 7'd36: g = 40'h61_51_49_45_43;
      7'd37: g = 40'h20_54_54_54_78; 7'd38: g = 40'h7F_48_44_44_38;
      7'd39: g = 40'h38_44_44_44_20; 7'd40: g = 40'h38_44_44_48_7F;
      7'd41: g = 40'h38_54_54_54_18; 7'd42: g = 40'h08_7E_09_01_02;
      7'd43: g = 40'h08_14_54_54_3C; 7'd44: g = 40'h7F_08_04_04_78;
      7'd45: g = 40'h00_44_7D_40_00; 7'd46: g = 40'h20_40_44_3D_00;
      7'd47: g = 40'h7F_10_28_44_00; 7'd48: g = 40'h00_41_7F_40_00;
      7'd49: g = 40'h7C_04_18_04_78; 7'd50: g = 40'h7C_08_04_04_78;
      7'd51: g = 40'h38_44_44_44_38; 7'd52: g = 40'h7C_14_14_14_08;
      7'd53: g = 40'h08_14_14_18_7C; 7'd54: g = 40'h7C_08_04_04_08;
      7'd55: g = 40'h48_54_54_54_20; 7'd56: g = 40'h04_3F_44_40_20;
      7'd57: g = 40'h3C_40_40_20_7C; 7'd58: g = 40'h1C_20_40_20_1C;
      7'd59: g = 40'h3C_40_30_40_3C; 7'd60: g = 40'h44_28_10_28_44;
      7'd61: g = 40'h0C_50_50_50_3C; 7'd62: g = 40'h44_64_54_4C_44;
      7'd63: g = 40'h00_60_60_00_00; 7'd64: g = 40'h00_80_60_00_00;
      7'd65: g = 40'h00_36_36_00_00; 7'd66: g = 40'h00_56_36_00_00;
      7'd67: g = 40'h00_00_7D_00_00; 7'd68: g = 40'h02_01_51_09_06;
      7'd69: g = 40'h08_08_08_08_08; 7'd70: g = 40'h40_40_40_40_40;
      7'd71: g = 40'h08_08_3E_08_08; 7'd72: g = 40'h14_14_14_14_14;
      7'd73: g = 40'h20_10_08_04_02; 7'd74: g = 40'h02_04_08_10_20;
      7'd75: g = 40'h00_00_7F_00_00; 7'd76: g = 40'h00_1C_22_41_00;
      7'd77: g = 40'h00_41_22_1C_00; 7'd78: g = 40'h00_7F_41_41_00;
      7'd79: g = 40'h00_41_41_7F_00; 7'd80: g = 40'h08_36_41_41_00;
      7'd81: g = 40'h00_41_41_36_08; 7'd82: g = 40'h00_03_00_03_00;
      7'd83: g = 40'h03_00_03_00_00; 7'd84: g = 40'h14_7F_14_7F_14;
      7'd85: g = 40'h24_2A_7F_2A_12; 7'd86: g = 40'h23_13_08_64_62;
      7'd87: g = 40'h36_49_55_22_50; 7'd88: g = 40'h14_08_3E_08_14;
      7'd89: g = 40'h3E_41_5D_55_1E; 7'd90: g = 40'h08_14_22_41_00;
      7'd91: g = 40'h00_41_22_14_08; 7'd92: g = 40'h04_02_01_02_04;
      7'd93: g = 40'h08_04_08_10_08; 7'd94: g = 40'h7C_12_11_12_7C;
      7'd95: g = 40'h7D_12_11_12_7D; 7'd96: g = 40'h3D_42_41_42_3D;
      7'd97: g = 40'h20_55_54_55_78; 7'd98: g = 40'h21_54_54_54_79;
      7'd99: g = 40'h39_44_44_44_39;
      default: g = 40'h0;
    endcase
    return g;
  endfunction

endpackage

// ===== src/lmfb_front.sv =====
// lmfb_front: accepts commands, resolves glyphs and range checks, fills a two-entry queue
// depends on lmfb_pkg
`timescale 1ns / 1ps
module lmfb_front import lmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic signed [7:0] x_pos,
  input  logic [3:0]  y_pos,
  input  logic        pixel_on,
  input  logic [7:0]  char_code,
  input  logic [63:0] bitmap,
  input  logic [5:0]  width,
  input  logic        back_pop,
  output logic        q_valid,
  output cmd_t        q_head,
  input  logic        back_idle
);

  cmd_t       q_mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cmd;
  logic signed [8:0] xw;

  assign xw = signed'({3'b000, width});

  always_comb begin
    cmd.opcode   = opcode;
    cmd.x_pos    = x_pos;
    cmd.y_pos    = y_pos;
    cmd.pixel_on = pixel_on;
    cmd.glyph    = glyph_rom(glyph_index(char_code));
    cmd.bitmap   = bitmap;
    cmd.bad      = (opcode > OP_REFRESH) ||
                   (opcode == OP_PIXEL &&
                    (x_pos < 0 || 9'(signed'(x_pos)) >= xw || y_pos > 4'd7));
  end

  // one command in flight at a time: busy until the queue is empty and the back is idle
  assign busy    = (count != 2'd0) || !back_idle;
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_head  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (back_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(back_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst) begin
      assert (!(back_pop && count == 2'd0)) else $error("pop from empty queue");
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue overflow");
  a_push_busy: assert property (@(posedge clk) disable iff (rst) push |=> busy)
    else $error("busy not raised after accept");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) back_pop |-> q_valid)
    else $error("pop without entry");

endmodule

// ===== src/lmfb_back.sv =====
// lmfb_back: executes queued commands on the row registers and streams refresh rows
// depends on lmfb_pkg
`timescale 1ns / 1ps
module lmfb_back import lmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_head,
  output logic        back_pop,
  output logic        back_idle,
  input  logic [5:0]  width,
  input  logic [2:0]  mods,
  input  logic        flip_view,
  output logic        done,
  output logic        status,
  output logic        is_row,
  output logic [3:0]  row_register,
  output logic [31:0] row_data,
  output logic        last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ROWS = 1'b1;

  logic [FB_WIDTH-1:0] frame_rows [ROWS];
  logic        state;
  logic [2:0]  row_cnt;
  logic        is_ref;
  logic [FB_WIDTH-1:0] wmask [ROWS];
  logic [FB_WIDTH-1:0] wval  [ROWS];
  logic [FB_WIDTH-1:0] src;
  logic [31:0] word;
  logic [2:0]  ry;

  assign is_ref    = q_head.opcode == OP_CLEAR || q_head.opcode == OP_REFRESH;
  assign back_pop  = q_valid && state == ST_IDLE;
  assign back_idle = state == ST_IDLE;

  // per-column write masks for the drawing commands, clipped at the display width
  always_comb begin
    logic signed [9:0] cx;
    logic [6:0] gcol;
    logic [7:0] brow;
    for (int r = 0; r < ROWS; r++) begin
      wmask[r] = '0;
      wval[r]  = '0;
    end
    for (int c = 0; c < FB_WIDTH; c++) begin
      cx = 10'(c) - 10'(signed'(q_head.x_pos));
      if (c < width) begin
        case (q_head.opcode)
          OP_PIXEL: begin
            if (!q_head.bad && cx == 10'sd0) begin
              wmask[q_head.y_pos[2:0]][c] = 1'b1;
              wval[q_head.y_pos[2:0]][c]  = q_head.pixel_on;
            end
          end
          OP_CHAR: begin
            if (cx >= 10'sd0 && cx < 10'sd5) begin
              gcol = q_head.glyph[8*(4-cx[2:0]) +: 7];
              for (int r = 0; r < 7; r++) begin
                wmask[r][c] = 1'b1;
                wval[r][c]  = gcol[r];
              end
            end else if (cx == 10'sd5) begin
              for (int r = 0; r < ROWS; r++) wmask[r][c] = 1'b1;
            end
          end
          OP_BITMAP: begin
            if (cx >= 10'sd0 && cx < 10'sd8) begin
              for (int r = 0; r < ROWS; r++) begin
                brow = q_head.bitmap[8*r +: 8];
                wmask[r][c] = 1'b1;
                wval[r][c]  = brow[3'd7 - cx[2:0]];
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // one row word per cycle during refresh
  assign ry  = flip_view ? 3'd7 - row_cnt : row_cnt;
  assign src = frame_rows[ry];
  always_comb begin
    logic [5:0] x;
    word = '0;
    for (int d = 0; d < MAX_MODULES; d++) begin
      for (int b = 0; b < 8; b++) begin
        x = 6'(d * 8 + b);
        if (flip_view) x = width - 6'd1 - x;
        if (3'(d) < mods && src[x[4:0]]) word[8*d + 7 - b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) frame_rows[r] <= '0;
    end else if (back_pop) begin
      for (int r = 0; r < ROWS; r++) begin
        if (q_head.opcode == OP_CLEAR) frame_rows[r] <= '0;
        else frame_rows[r] <= (frame_rows[r] & ~wmask[r]) | (wval[r] & wmask[r]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      row_cnt <= 3'd0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (back_pop) begin
            if (is_ref) begin
              state   <= ST_ROWS;
              row_cnt <= 3'd0;
            end else begin
              done <= 1'b1;
            end
          end
        end
        ST_ROWS: begin
          done    <= 1'b1;
          row_cnt <= row_cnt + 3'd1;
          if (row_cnt == 3'd7) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROWS) begin
      status       <= 1'b0;
      is_row       <= 1'b1;
      row_register <= 4'd1 + 4'(row_cnt);
      row_data     <= word;
      last         <= row_cnt == 3'd7;
    end else begin
      status       <= q_head.bad;
      is_row       <= 1'b0;
      row_register <= 4'd0;
      row_data     <= '0;
      last         <= 1'b1;
    end
  end

  a_rows_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROWS && row_cnt == 3'd7) |=> (state == ST_IDLE && done && last))
    else $error("refresh did not end on row seven");
  a_no_pop_rows: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROWS |-> !back_pop)
    else $error("command taken during refresh");
  a_row_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROWS |=> done)
    else $error("row beat missing");

endmodule

// ===== src/led_matrix_text_framebuffer_core.sv =====
// led_matrix_text_framebuffer_core: top level of the led matrix framebuffer
// depends on lmfb_pkg, lmfb_front, lmfb_back
`timescale 1ns / 1ps
// A command is taken when start is high and busy is low. Drawing commands (set pixel,
// character, bitmap) and unused opcodes give one result beat once the command has been
// popped from the queue and executed; refresh and clear give eight row beats on consecutive
// cycles once the back end is in its row state, one per row read from the row registers,
// the last with last high. Busy stays high until the back end has finished. Results come
// with done high for exactly one cycle each and cannot be stalled. Configuration writes
// (wr_en, wr_index, wr_data) are taken at once and must only be made while busy is low.
module led_matrix_text_framebuffer_core import lmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic signed [7:0] x_pos,
  input  logic [3:0]  y_pos,
  input  logic        pixel_on,
  input  logic [7:0]  char_code,
  input  logic [63:0] bitmap,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [2:0]  wr_data,
  output logic        done,
  output logic        status,
  output logic        is_row,
  output logic [3:0]  row_register,
  output logic [31:0] row_data,
  output logic        last
);

  logic [2:0] device_count;
  logic       flip_view;
  logic [2:0] mods;
  logic [5:0] width;
  logic       q_valid, back_pop, back_idle;
  cmd_t       q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_count <= 3'd4;
      flip_view    <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DEVICE_COUNT: device_count <= wr_data;
        CFG_FLIP_VIEW:    flip_view    <= wr_data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one module, anything above the chain limit as the limit
  always_comb begin
    if (device_count == 3'd0) mods = 3'd1;
    else if (device_count > 3'(MAX_MODULES)) mods = 3'(MAX_MODULES);
    else mods = device_count;
  end
  assign width = {mods, 3'b000};

  lmfb_front u_front (
    .clk, .rst, .start, .busy, .opcode, .x_pos, .y_pos, .pixel_on, .char_code, .bitmap,
    .width, .back_pop, .q_valid, .q_head, .back_idle
  );

  lmfb_back u_back (
    .clk, .rst, .q_valid, .q_head, .back_pop, .back_idle, .width, .mods, .flip_view,
    .done, .status, .is_row, .row_register, .row_data, .last
  );

  a_cfg_range: assert property (@(posedge clk) disable iff (rst)
    mods >= 3'd1 && mods <= 3'(MAX_MODULES))
    else $error("module count out of range");
  a_row_reg: assert property (@(posedge clk) disable iff (rst)
    (done && is_row) |-> (row_register >= 4'd1 && row_register <= 4'd8))
    else $error("bad row register");
  a_beat_busy: assert property (@(posedge clk) disable iff (rst)
    (done && !last) |-> busy)
    else $error("busy dropped mid refresh");

endmodule

// ===== sim/lmfb_checker.sv =====
// lmfb_checker: watches command and result beats of the led matrix framebuffer and checks them
// depends on lmfb_pkg for opcodes and register indexes
`timescale 1ns / 1ps
module lmfb_checker import lmfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  opcode,
  input  logic signed [7:0] x_pos,
  input  logic [3:0]  y_pos,
  input  logic        pixel_on,
  input  logic [7:0]  char_code,
  input  logic [63:0] bitmap,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [2:0]  wr_data,
  input  logic        done,
  input  logic        status,
  input  logic        is_row,
  input  logic [3:0]  row_register,
  input  logic [31:0] row_data,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic        status;
    logic        is_row;
    logic [3:0]  row_register;
    logic [31:0] row_data;
    logic        last;
  } beat_t;

  beat_t       beat_queue[$];
  logic [31:0] pixels[8];
  logic [2:0]  dev_count;
  logic        flip;

  assign pending = beat_queue.size();

  // font lookup kept apart from the package so the check does not share the design's table
  function automatic logic [39:0] font_col(input logic [7:0] c);
    logic [7:0] punct[31];
    logic [7:0] swede[6];
    logic [39:0] rom[100];
    int idx;
    punct = '{8'h2E,8'h2C,8'h3A,8'h3B,8'h21,8'h3F,8'h2D,8'h5F,8'h2B,8'h3D,8'h2F,8'h5C,
              8'h7C,8'h28,8'h29,8'h5B,8'h5D,8'h7B,8'h7D,8'h27,8'h22,8'h23,8'h24,8'h25,
              8'h26,8'h2A,8'h40,8'h3C,8'h3E,8'h5E,8'h7E};
    swede = '{8'hC5,8'hC4,8'hD6,8'hE5,8'hE4,8'hF6};
    rom = '{40'h0,
      40'h3E5149453E,40'h00427F4000,40'h4261514946,40'h2141454B31,40'h1814127F10,
      40'h2745454539,40'h3C4A494930,40'h0171090503,40'h3649494936,40'h064949291E,
      40'h7E1111117E,40'h7F49494936,40'h3E41414122,40'h7F4141221C,40'h7F49494941,
      40'h7F09090901,40'h3E4149497A,40'h7F0808087F,40'h00417F4100,40'h2040413F01,
      40'h7F08142241,40'h7F40404040,40'h7F020C027F,40'h7F0408107F,40'h3E4141413E,
      40'h7F09090906,40'h3E4151215E,40'h7F09192946,40'h4649494931,40'h01017F0101,
      40'h3F4040403F,40'h1F2040201F,40'h7F2018207F,40'h6314081463,40'h0304780403,
      40'h6151494543,
      40'h2054545478,40'h7F48444438,40'h3844444420,40'h384444487F,40'h3854545418,
      40'h087E090102,40'h081454543C,40'h7F08040478,40'h00447D4000,40'h2040443D00,
      40'h7F10284400,40'h00417F4000,40'h7C04180478,40'h7C08040478,40'h3844444438,
      40'h7C14141408,40'h081414187C,40'h7C08040408,40'h4854545420,40'h043F444020,
      40'h3C4040207C,40'h1C2040201C,40'h3C4030403C,40'h4428102844,40'h0C5050503C,
      40'h4464544C44,
      40'h0060600000,40'h0080600000,40'h0036360000,40'h0056360000,40'h00007D0000,
      40'h0201510906,40'h0808080808,40'h4040404040,40'h08083E0808,40'h1414141414,
      40'h2010080402,40'h0204081020,40'h00007F0000,40'h001C224100,40'h0041221C00,
      40'h007F414100,40'h0041417F00,40'h0836414100,40'h0041413608,40'h0003000300,
      40'h0300030000,40'h147F147F14,40'h242A7F2A12,40'h2313086462,40'h3649552250,
      40'h14083E0814,40'h3E415D551E,40'h0814224100,40'h0041221408,40'h0402010204,
      40'h0804081008,
      40'h7C1211127C,40'h7D1211127D,40'h3D4241423D,40'h2055545578,40'h2154545479,
      40'h3944444439};
    idx = 0;
    if (c >= 8'h30 && c <= 8'h39) idx = 1 + c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h5A) idx = 11 + c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) idx = 37 + c - 8'h61;
    else begin
      for (int i = 0; i < 31; i++) if (punct[i] == c) idx = 63 + i;
      for (int i = 0; i < 6; i++) if (swede[i] == c) idx = 94 + i;
    end
    return rom[idx];
  endfunction

  function automatic int view_width();
    int n;
    n = dev_count;
    if (n < 1) n = 1;
    if (n > MAX_MODULES) n = MAX_MODULES;
    return n * 8;
  endfunction

  function automatic void plot(input int x, input int y, input logic on);
    if (x < 0 || x >= view_width() || y < 0 || y > 7) return;
    pixels[y][x] = on;
  endfunction

  function automatic void queue_rows();
    beat_t b;
    int w, x, y;
    w = view_width();
    for (int r = 0; r < 8; r++) begin
      b = '0;
      b.is_row = 1'b1;
      b.row_register = 4'(r + 1);
      b.last = (r == 7);
      for (int d = 0; d < w / 8; d++)
        for (int k = 0; k < 8; k++) begin
          x = d * 8 + k;
          y = r;
          if (flip) begin
            x = w - 1 - x;
            y = 7 - r;
          end
          if (pixels[y][x]) b.row_data[8 * d + 7 - k] = 1'b1;
        end
      beat_queue.push_back(b);
    end
  endfunction

  function automatic void apply_command();
    beat_t b;
    logic [39:0] g;
    int x;
    b = '0;
    b.last = 1'b1;
    x = x_pos;
    case (opcode)
      OP_CLEAR: begin
        foreach (pixels[i]) pixels[i] = '0;
        queue_rows();
        return;
      end
      OP_REFRESH: begin
        queue_rows();
        return;
      end
      OP_PIXEL: begin
        if (x < 0 || x >= view_width() || y_pos > 7) b.status = 1'b1;
        else plot(x, y_pos, pixel_on);
      end
      OP_CHAR: begin
        g = font_col(char_code);
        for (int c = 0; c < 5; c++)
          for (int r = 0; r < 7; r++) plot(x + c, r, g[8 * (4 - c) + r]);
        for (int r = 0; r < 8; r++) plot(x + 5, r, 1'b0);
      end
      OP_BITMAP: begin
        for (int r = 0; r < 8; r++)
          for (int c = 0; c < 8; c++) plot(x + c, r, bitmap[8 * r + 7 - c]);
      end
      default: b.status = 1'b1;
    endcase
    beat_queue.push_back(b);
  endfunction

  always @(posedge clk) begin
    beat_t seen, want;
    if (rst) begin
      foreach (pixels[i]) pixels[i] = '0;
      dev_count = 3'd4;
      flip = 1'b0;
      fail_count = 0;
      beat_queue.delete();
    end else begin
      if (done) begin
        seen = '{status, is_row, row_register, row_data, last};
        if (beat_queue.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, seen);
          fail_count++;
        end else begin
          want = beat_queue.pop_front();
          if (seen !== want) begin
            $display("%0t: mismatch expected st=%b row=%b reg=%0d data=%h last=%b",
                     $time, want.status, want.is_row, want.row_register, want.row_data,
                     want.last);
            $display("%0t:          actual   st=%b row=%b reg=%0d data=%h last=%b",
                     $time, status, is_row, row_register, row_data, last);
            fail_count++;
          end
        end
      end
      if (start && !busy) apply_command();
      if (wr_en) begin
        if (wr_index == CFG_DEVICE_COUNT) dev_count = wr_data;
        else flip = wr_data[0];
      end
    end
  end

endmodule

// ===== sim/tb_led_matrix_text_framebuffer_core.sv =====
// tb_led_matrix_text_framebuffer_core: stimulus and verdict for the led matrix framebuffer
// depends on lmfb_pkg, led_matrix_text_framebuffer_core and lmfb_checker
`timescale 1ns / 1ps
module tb_led_matrix_text_framebuffer_core import lmfb_pkg::*;;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = '0;
  logic signed [7:0] x_pos = '0;
  logic [3:0]  y_pos = '0;
  logic        pixel_on = 1'b0;
  logic [7:0]  char_code = '0;
  logic [63:0] bitmap = '0;
  logic        wr_en = 1'b0;
  logic        wr_index = 1'b0;
  logic [2:0]  wr_data = '0;
  logic        done, status, is_row, last;
  logic [3:0]  row_register;
  logic [31:0] row_data;
  int          fail_count, pending;
  bit          calm;     // no idle gaps while set

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  led_matrix_text_framebuffer_core u_top (.*);

  lmfb_checker u_chk (.*);

  // one command beat: optional idle gap, then hold start until the block takes it;
  // start stays high on return so the next beat can follow without a gap
  task automatic send_cmd(input logic [2:0] op, input logic signed [7:0] x,
                          input logic [3:0] y, input logic on, input logic [7:0] ch,
                          input logic [63:0] bm);
    while (!calm && $urandom_range(99) < 24) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    x_pos     <= x;
    y_pos     <= y;
    pixel_on  <= on;
    char_code <= ch;
    bitmap    <= bm;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // register writes only with the block idle and every expected beat in
  task automatic write_reg(input logic idx, input logic [2:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);   // only a margin, nothing is in flight once busy is low and every beat is in
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(3))
      0:       return 8'($urandom_range(8'h20, 8'h7E));
      1:       return 8'($urandom_range(8'hC0, 8'hFF));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_cmd();
    logic [2:0] op;
    int sel;
    sel = $urandom_range(99);
    // mostly drawing, with regular refreshes so the buffer is seen often
    if (sel < 30)      op = OP_PIXEL;
    else if (sel < 52) op = OP_CHAR;
    else if (sel < 70) op = OP_BITMAP;
    else if (sel < 88) op = OP_REFRESH;
    else if (sel < 93) op = OP_CLEAR;
    else               op = 3'($urandom_range(5, 7));
    send_cmd(op,
             ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40) - 6),
             ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(7)),
             1'($urandom), pick_char(), {$urandom, $urandom});
  endtask

  // hard stop in case the handshake hangs
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [2:0] dc_set[6];
    int waited;
    dc_set = '{3'd1, 3'd4, 3'd2, 3'd0, 3'd7, 3'd3};
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed beats at reset settings
    send_cmd(OP_REFRESH, 0, 0, 0, 0, 0);
    send_cmd(OP_PIXEL, 0, 0, 1, 0, 0);
    send_cmd(OP_PIXEL, 31, 7, 1, 0, 0);
    send_cmd(OP_PIXEL, 32, 0, 1, 0, 0);         // beyond the right edge
    send_cmd(OP_PIXEL, -128, 0, 1, 0, 0);
    send_cmd(OP_PIXEL, 127, 15, 1, 0, 0);
    send_cmd(OP_PIXEL, 3, 8, 1, 0, 0);          // row out of range
    send_cmd(OP_CHAR, 2, 0, 0, 8'h41, 0);
    send_cmd(OP_CHAR, -3, 0, 0, 8'hC5, 0);      // clipped on the left
    send_cmd(OP_CHAR, 29, 0, 0, 8'hF6, 0);      // clipped on the right
    send_cmd(OP_CHAR, 10, 0, 0, 8'h01, 0);      // no glyph, draws blank
    send_cmd(OP_BITMAP, 12, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_cmd(OP_CHAR, 13, 0, 0, 8'h7E, 0);      // leaves row 7, clears spacing column
    send_cmd(OP_BITMAP, -4, 0, 0, 0, 64'hA5C3_0F81_7E18_3CF0);
    send_cmd(OP_BITMAP, 28, 0, 0, 0, 64'h0123_4567_89AB_CDEF);
    send_cmd(OP_REFRESH, 0, 0, 0, 0, 0);
    send_cmd(3'd5, 0, 0, 0, 0, 0);
    send_cmd(3'd7, 0, 0, 0, 0, 0);
    write_reg(CFG_FLIP_VIEW, 3'd1);
    send_cmd(OP_REFRESH, 0, 0, 0, 0, 0);
    write_reg(CFG_DEVICE_COUNT, 3'd1);
    send_cmd(OP_PIXEL, 8, 0, 1, 0, 0);          // hidden column
    send_cmd(OP_REFRESH, 0, 0, 0, 0, 0);
    send_cmd(OP_CLEAR, 0, 0, 0, 0, 0);

    // random phases over several register settings, one with no idling at all
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_DEVICE_COUNT, dc_set[ph]);
      write_reg(CFG_FLIP_VIEW, 3'(ph & 1));
      calm = (ph == 2);
      for (int i = 0; i < 70; i++) random_cmd();
    end
    calm = 1'b0;
    start <= 1'b0;

    // drain, then let any in-flight beat arrive
    waited = 0;
    while (pending != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lmfb_pkg.sv
src/lmfb_front.sv
src/lmfb_back.sv
src/led_matrix_text_framebuffer_core.sv
sim/lmfb_checker.sv
sim/tb_led_matrix_text_framebuffer_core.sv
